// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

    // Field widths of the command and response items
    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int LIN_OUT_W = 12;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Character codes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_BLANK,
        ST_PLACE,
        ST_CLEAR,
        ST_RESULT
    } tcw_state_t;

    typedef struct packed {
        logic                 valid;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [LIN_OUT_W-1:0] lin;
        logic [CHAR_W-1:0]    cell_char;
        logic [ATTR_W-1:0]    cell_attr;
    } tcw_result_t;

endpackage

`default_nettype wire

// ===== design/tcw_in_if.sv =====
// Command channel: mode, character and cell index with valid and ready.
`default_nettype none

interface tcw_in_if
    import tcw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, output mode, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input mode, input char_code, input cell_index,
                  output ready);
endinterface

`default_nettype wire

// ===== design/tcw_out_if.sv =====
// Response channel: cursor position and cell contents with valid and ready.
`default_nettype none

interface tcw_out_if
    import tcw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [LIN_OUT_W-1:0] cursor_linear;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;

    modport source (output valid, output cursor_row, output cursor_col,
                    output cursor_linear, output cell_char, output cell_attr,
                    input ready);
    modport sink (input valid, input cursor_row, input cursor_col,
                  input cursor_linear, input cell_char, input cell_attr,
                  output ready);
endinterface

`default_nettype wire

// ===== design/text_console_writer.sv =====
// Top level of the text console writer: attribute register, screen store and response register.
//
//   channel  | kind          | contents
//   ---------+---------------+-------------------------------------------------
//   cmd      | valid / ready | mode, char_code, cell_index
//   rsp      | valid / ready | cursor_row, cursor_col, cursor_linear, cell_char,
//            |               | cell_attr
//   cfg      | write enable  | cfg_wdata: attribute byte for written and blank cells
//
// A put that scrolls first runs the one-cell-a-cycle copy of the store and the blank sweep of its
// bottom row, and then places the byte. A clear makes one store write per cell.
// After reset a pass that writes all ROWS*COLUMNS cells blanks the store before cmd is ready.
// The response register lets an item finish while the previous result waits on rsp.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tcw_in_if.sink                 cmd,
    tcw_out_if.source              rsp,
    input  wire logic              cfg_we,
    input  wire logic [ATTR_W-1:0] cfg_wdata
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [ATTR_W-1:0]    attr_reg;
    logic                 rsp_valid_reg;
    logic [ROW_OUT_W-1:0] row_reg;
    logic [COL_OUT_W-1:0] col_reg;
    logic [LIN_OUT_W-1:0] lin_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [ATTR_W-1:0]    cattr_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;
    tcw_result_t          res;
    logic                 res_taken;

    assign res_taken = res.valid && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= RESET_ATTR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (res_taken)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            row_reg   <= res.row;
            col_reg   <= res.col;
            lin_reg   <= res.lin;
            char_reg  <= res.cell_char;
            cattr_reg <= res.cell_attr;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cursor_row    = row_reg;
    assign rsp.cursor_col    = col_reg;
    assign rsp.cursor_linear = lin_reg;
    assign rsp.cell_char     = char_reg;
    assign rsp.cell_attr     = cattr_reg;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .attr      (attr_reg),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .res       (res),
        .res_taken (res_taken)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== design/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/tcw_seq.sv =====
// Sequencer: cursor state, the cell sweep counter and all accesses to the screen store.
`default_nettype none

module tcw_seq
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    tcw_in_if.sink                                    cmd,
    input  wire logic [ATTR_W-1:0]                    attr,
    input  wire logic [CELL_W-1:0]                    ram_rdata,
    output logic                                      ram_we,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]      ram_waddr,
    output logic      [CELL_W-1:0]                    ram_wdata,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]      ram_raddr,
    output tcw_result_t                               res,
    input  wire logic                                 res_taken
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    tcw_state_t         state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic               hit_reg;

    logic               done;
    logic               wrap;
    logic [ROW_W-1:0]   row_wrap;
    logic [COL_W-1:0]   col_wrap;
    logic [31:0]        put_lin;
    logic [31:0]        copy_src;
    logic [31:0]        place_addr;
    logic [31:0]        cmd_idx;
    logic [31:0]        res_lin;
    logic [31:0]        row_ext;
    logic [31:0]        col_ext;
    logic               accept;

    assign accept  = cmd.valid && cmd.ready;
    assign cmd_idx = 32'(cmd.cell_index);

    // A printable byte with a pending wrap lands on column zero of the next row.
    assign wrap     = (col_reg >= COLUMNS);
    assign row_wrap = wrap ? row_reg + 1'b1 : row_reg;
    assign col_wrap = wrap ? '0 : col_reg;
    assign put_lin  = 32'(row_wrap) * 32'(COLUMNS) + 32'(col_wrap);

    assign copy_src   = 32'(cnt_reg) + 32'(COLUMNS);
    assign place_addr = 32'(COPY_N) + 32'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= cmd.mode;
            char_reg <= cmd.char_code;
            idx_reg  <= cmd_idx[ADDR_W-1:0];
            hit_reg  <= (cmd_idx < 32'(CELLS));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg[ADDR_W-1:0];
        ram_wdata  = {attr, CH_SPACE};
        ram_raddr  = idx_reg;
        cmd.ready  = 1'b0;
        done       = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Power-up pass that fills the store with blanks of the reset attribute.
                ram_we    = 1'b1;
                ram_wdata = {RESET_ATTR, CH_SPACE};
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                ram_raddr = cmd_idx[ADDR_W-1:0];
                if (cmd.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_PUT:
                    begin
                        if (char_reg == CH_NEWLINE)
                        begin
                            if (row_reg < ROWS)
                            begin
                                row_next = row_reg + 1'b1;
                            end
                            col_next = '0;
                            done     = 1'b1;
                        end
                        else if (char_reg == CH_BACKSPACE)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            done = 1'b1;
                        end
                        else if (row_wrap >= ROWS)
                        begin
                            // Scroll first; the byte is placed once the bottom row is blank.
                            row_next   = ROW_W'(ROWS - 1);
                            col_next   = col_wrap;
                            cnt_next   = '0;
                            state_next = ST_COPY;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = put_lin[ADDR_W-1:0];
                            ram_wdata = {attr, char_reg};
                            row_next  = row_wrap;
                            col_next  = col_wrap + 1'b1;
                            done      = 1'b1;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
            ST_COPY:
            begin
                // Read one row ahead and write the cell fetched in the previous cycle.
                if (cnt_reg != CNT_W'(COPY_N))
                begin
                    ram_raddr = copy_src[ADDR_W-1:0];
                end
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(cnt_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == CNT_W'(COPY_N))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                ram_we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = place_addr[ADDR_W-1:0];
                ram_wdata = {attr, char_reg};
                col_next  = col_reg + 1'b1;
                done      = 1'b1;
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    row_next = '0;
                    col_next = '0;
                    done     = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The result leaves straight away when the output slot is free.
        if (done)
        begin
            state_next = res_taken ? ST_IDLE : ST_RESULT;
        end
    end

    assign row_ext = 32'(row_next);
    assign col_ext = 32'(col_next);
    assign res_lin = row_ext * 32'(COLUMNS) + col_ext;

    always_comb
    begin
        res.valid = done;
        res.row   = row_ext[ROW_OUT_W-1:0];
        res.col   = col_ext[COL_OUT_W-1:0];
        res.lin   = res_lin[LIN_OUT_W-1:0];
        if (mode_reg == MODE_READ && hit_reg)
        begin
            res.cell_char = ram_rdata[CHAR_W-1:0];
            res.cell_attr = ram_rdata[CELL_W-1:CHAR_W];
        end
        else
        begin
            res.cell_char = '0;
            res.cell_attr = '0;
        end
    end

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted item did not start execution");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_RESULT) |-> !ram_we)
        else $error("screen store written while no item is at work");

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COLUMNS && row_reg <= ROWS)
        else $error("cursor outside its range");

    a_scroll_lands_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |-> row_reg == ROW_W'(ROWS - 1) && cnt_reg <= CNT_W'(COPY_N))
        else $error("scroll sweep out of step with the cursor");

endmodule

`default_nettype wire
